>>> rtl/isd_pkg.sv
package isd_pkg;

	// Velocity components are signed Q11.12
	localparam int VEL_W   = 24;
	localparam int THR_W   = 23;
	localparam int TICK_W  = 16;
	localparam int TIME_W  = 32;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 2;

	// Square of one component, sum of three squares, squared threshold
	localparam int SQ_W    = 2 * VEL_W - 1;
	localparam int SUM_W   = SQ_W + 2;
	localparam int LIM_W   = 2 * THR_W;

	typedef enum logic [IDX_W-1:0] {
		REG_SLEEP_ENABLE      = 2'd0,
		REG_LINEAR_THRESHOLD  = 2'd1,
		REG_ANGULAR_THRESHOLD = 2'd2,
		REG_SLEEP_DELAY       = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] lin_x;
		logic signed [VEL_W-1:0] lin_y;
		logic signed [VEL_W-1:0] lin_z;
		logic signed [VEL_W-1:0] ang_x;
		logic signed [VEL_W-1:0] ang_y;
		logic signed [VEL_W-1:0] ang_z;
		logic                    body_static;
		logic                    wake_request;
		logic [TICK_W-1:0]       tick_time;
		logic                    last_body;
	} sample_t;

	typedef struct packed {
		logic              sleeping;
		logic [TIME_W-1:0] quiet_us;
		logic              entered_sleep;
		logic              woke_up;
	} result_t;

	// Classified item passed from front to back
	typedef struct packed {
		logic              moving;
		logic              wake_request;
		logic [TICK_W-1:0] tick_time;
		logic              last_body;
	} class_t;

	typedef struct packed {
		logic              sleep_enable;
		logic [THR_W-1:0]  linear_threshold;
		logic [THR_W-1:0]  angular_threshold;
		logic [TIME_W-1:0] sleep_delay;
	} cfg_t;

endpackage

>>> rtl/inactivity_sleep_detector_top.sv
// Inactivity detector for a group of coupled bodies. Feed one sample per body
// per tick and mark the final body of the tick with last_body; that sample
// yields one result, the others none. Samples are taken one per clock cycle
// as long as full stays low. A two-stage front (component squares, then sums
// and threshold compare) classifies each body as moving or quiet and places it
// in a small queue of MID_DEPTH entries; the back end folds the classified
// items into the group state, one per cycle while a closing item finds room
// in the output queue of OUT_DEPTH entries, into which it writes results. A
// closing sample passes stage 1, stage 2 and both queues. full rises when
// the middle queue together with the two front stages holds MID_DEPTH items,
// which, for a MID_DEPTH of four or more, happens only while the output
// queue is not drained. Registers clear to zero on reset, so the group starts
// awake with detection disabled; write them only while no item is in flight.
module inactivity_sleep_detector_top #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  isd_pkg::sample_t            sample,
	output logic                        empty,
	input  logic                        pop,
	output isd_pkg::result_t            result,
	input  logic                        wr_en,
	input  logic [isd_pkg::IDX_W-1:0]   wr_index,
	input  logic [isd_pkg::DATA_W-1:0]  wr_data
);

	isd_pkg::cfg_t     cfg_q;
	logic              mid_push;
	isd_pkg::class_t   mid_wdata;
	isd_pkg::class_t   mid_rdata;
	logic              mid_pop;
	logic              mid_empty;
	logic              mid_full;
	logic              out_push;
	isd_pkg::result_t  out_wdata;
	logic              out_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (isd_pkg::reg_index_t'(wr_index))
				isd_pkg::REG_SLEEP_ENABLE: begin
					cfg_q.sleep_enable <= wr_data[0];
				end
				isd_pkg::REG_LINEAR_THRESHOLD: begin
					cfg_q.linear_threshold <= wr_data[isd_pkg::THR_W-1:0];
				end
				isd_pkg::REG_ANGULAR_THRESHOLD: begin
					cfg_q.angular_threshold <= wr_data[isd_pkg::THR_W-1:0];
				end
				isd_pkg::REG_SLEEP_DELAY: begin
					cfg_q.sleep_delay <= wr_data[isd_pkg::TIME_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	isd_front #(
		.MID_DEPTH (MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.cfg       (cfg_q),
		.mid_pop   (mid_pop),
		.full      (full),
		.mid_push  (mid_push),
		.mid_item  (mid_wdata)
	);

	// front-to-back queue; the front never overruns it
	isd_queue #(
		.WIDTH ($bits(isd_pkg::class_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push && !mid_full),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.full   (mid_full)
	);

	isd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_item  (mid_rdata),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_wdata)
	);

	// result queue
	isd_queue #(
		.WIDTH ($bits(isd_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.full   (out_full)
	);

endmodule

>>> rtl/isd_queue.sv
module isd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic                           full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/isd_front.sv
module isd_front #(
	parameter int MID_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  isd_pkg::sample_t                 sample,
	input  isd_pkg::cfg_t                    cfg,
	input  logic                             mid_pop,
	output logic                             full,
	output logic                             mid_push,
	output isd_pkg::class_t                  mid_item
);

	localparam int CNT_W = $clog2(MID_DEPTH + 1);

	logic                                accept;
	logic [CNT_W-1:0]                    inflight_q;

	logic [isd_pkg::LIM_W-1:0]           lin_lim_q;
	logic [isd_pkg::LIM_W-1:0]           ang_lim_q;

	logic                                valid_s1;
	logic signed [2*isd_pkg::VEL_W-1:0]  lin_prod_s1 [3];
	logic signed [2*isd_pkg::VEL_W-1:0]  ang_prod_s1 [3];
	logic                                static_s1;
	logic                                req_s1;
	logic [isd_pkg::TICK_W-1:0]          tick_s1;
	logic                                last_s1;

	logic                                valid_s2;
	logic [isd_pkg::SUM_W-1:0]           lin_sum_s2;
	logic [isd_pkg::SUM_W-1:0]           ang_sum_s2;
	logic                                static_s2;
	logic                                req_s2;
	logic [isd_pkg::TICK_W-1:0]          tick_s2;
	logic                                last_s2;

	logic                                lin_fast;
	logic                                ang_fast;

	// credit check: items in the two stages plus those waiting in the queue
	assign full   = (inflight_q == CNT_W'(MID_DEPTH));
	assign accept = push && !full;

	// squared thresholds, refreshed every cycle from the config registers
	always_ff @(posedge clk) begin
		lin_lim_q <= cfg.linear_threshold * cfg.linear_threshold;
		ang_lim_q <= cfg.angular_threshold * cfg.angular_threshold;
	end

	// valid bits and in-flight count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			inflight_q <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			case ({accept, mid_pop})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	// stage 1: component squares
	always_ff @(posedge clk) begin
		if (accept) begin
			lin_prod_s1[0] <= sample.lin_x * sample.lin_x;
			lin_prod_s1[1] <= sample.lin_y * sample.lin_y;
			lin_prod_s1[2] <= sample.lin_z * sample.lin_z;
			ang_prod_s1[0] <= sample.ang_x * sample.ang_x;
			ang_prod_s1[1] <= sample.ang_y * sample.ang_y;
			ang_prod_s1[2] <= sample.ang_z * sample.ang_z;
			static_s1      <= sample.body_static;
			req_s1         <= sample.wake_request;
			tick_s1        <= sample.tick_time;
			last_s1        <= sample.last_body;
		end
	end

	// stage 2: sums of squares; squares are never negative
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			lin_sum_s2 <= isd_pkg::SUM_W'(lin_prod_s1[0][isd_pkg::SQ_W-1:0])
			            + isd_pkg::SUM_W'(lin_prod_s1[1][isd_pkg::SQ_W-1:0])
			            + isd_pkg::SUM_W'(lin_prod_s1[2][isd_pkg::SQ_W-1:0]);
			ang_sum_s2 <= isd_pkg::SUM_W'(ang_prod_s1[0][isd_pkg::SQ_W-1:0])
			            + isd_pkg::SUM_W'(ang_prod_s1[1][isd_pkg::SQ_W-1:0])
			            + isd_pkg::SUM_W'(ang_prod_s1[2][isd_pkg::SQ_W-1:0]);
			static_s2  <= static_s1;
			req_s2     <= req_s1;
			tick_s2    <= tick_s1;
			last_s2    <= last_s1;
		end
	end

	// classify against the limits and hand over to the queue
	assign lin_fast = lin_sum_s2 >
		{{(isd_pkg::SUM_W - isd_pkg::LIM_W){1'b0}}, lin_lim_q};
	assign ang_fast = ang_sum_s2 >
		{{(isd_pkg::SUM_W - isd_pkg::LIM_W){1'b0}}, ang_lim_q};

	assign mid_push              = valid_s2;
	assign mid_item.moving       = !static_s2 && (lin_fast || ang_fast);
	assign mid_item.wake_request = req_s2;
	assign mid_item.tick_time    = tick_s2;
	assign mid_item.last_body    = last_s2;

endmodule

>>> rtl/isd_back.sv
module isd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  isd_pkg::cfg_t      cfg,
	input  logic               mid_empty,
	input  isd_pkg::class_t    mid_item,
	output logic               mid_pop,
	input  logic               out_full,
	output logic               out_push,
	output isd_pkg::result_t   out_item
);

	logic                        asleep_q;
	logic [isd_pkg::TIME_W-1:0]  quiet_q;
	logic                        motion_q;
	logic                        request_q;

	logic                        motion;
	logic                        request;
	logic [isd_pkg::TIME_W:0]    quiet_sum;
	logic [isd_pkg::TIME_W-1:0]  quiet_sat;
	logic                        nxt_asleep;
	logic [isd_pkg::TIME_W-1:0]  nxt_quiet;
	logic                        entered;
	logic                        woke;

	// a closing item needs room for its result
	assign mid_pop  = !mid_empty && (!mid_item.last_body || !out_full);
	assign out_push = mid_pop && mid_item.last_body;

	assign motion    = motion_q || mid_item.moving;
	assign request   = request_q || mid_item.wake_request;
	assign quiet_sum = {1'b0, quiet_q} + {{(isd_pkg::TIME_W - isd_pkg::TICK_W + 1){1'b0}},
		mid_item.tick_time};
	assign quiet_sat = quiet_sum[isd_pkg::TIME_W] ? '1 : quiet_sum[isd_pkg::TIME_W-1:0];

	// end-of-tick decision, in priority order
	always_comb begin
		nxt_asleep = asleep_q;
		nxt_quiet  = quiet_q;
		entered    = 1'b0;
		woke       = 1'b0;
		if (!cfg.sleep_enable || request) begin
			woke       = asleep_q;
			nxt_asleep = 1'b0;
			nxt_quiet  = '0;
		end else if (asleep_q) begin
			nxt_asleep = 1'b1;
		end else if (motion) begin
			nxt_quiet = '0;
		end else begin
			nxt_quiet = quiet_sat;
			if (quiet_sat >= cfg.sleep_delay) begin
				nxt_asleep = 1'b1;
				entered    = 1'b1;
			end
		end
	end

	assign out_item.sleeping      = nxt_asleep;
	assign out_item.quiet_us      = nxt_quiet;
	assign out_item.entered_sleep = entered;
	assign out_item.woke_up       = woke;

	// group state and per-tick accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asleep_q  <= 1'b0;
			quiet_q   <= '0;
			motion_q  <= 1'b0;
			request_q <= 1'b0;
		end else if (mid_pop) begin
			if (mid_item.last_body) begin
				asleep_q  <= nxt_asleep;
				quiet_q   <= nxt_quiet;
				motion_q  <= 1'b0;
				request_q <= 1'b0;
			end else begin
				motion_q  <= motion;
				request_q <= request;
			end
		end
	end

endmodule

>>> rtl/isd_checker.sv
module isd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input isd_pkg::result_t result
);

	// a tick that enters sleep leaves the group asleep
	a_entered_asleep: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.entered_sleep |-> result.sleeping)
		else $error("entered_sleep without sleeping");

	// a wake leaves the group awake with no quiet time
	a_woke_awake: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.woke_up |-> !result.sleeping && result.quiet_us == '0)
		else $error("woke_up with group still asleep or idle time kept");

	// entering sleep and waking are exclusive
	a_enter_or_wake: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(result.entered_sleep && result.woke_up))
		else $error("entered_sleep and woke_up together");

	// a waiting result holds until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

endmodule

bind inactivity_sleep_detector_top isd_checker u_isd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
